### hw/rtl/tsam_pkg.sv
// Shared types, constants and helper functions of the texture sampler.
package tsam_pkg;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_COLOR  = 2'd1,
      ACT_NORMAL = 2'd2,
      ACT_BUMP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_TEX_WIDTH   = 3'd0,
      REG_TEX_HEIGHT  = 3'd1,
      REG_FILTER_MODE = 3'd2,
      REG_WRAP_MODE   = 3'd3,
      REG_STEP_U      = 3'd4,
      REG_STEP_V      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [1:0] du;
      logic signed [1:0] dv;
      logic signed [3:0] wx;
      logic signed [3:0] wy;
   } bump_pt_type;

   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [40:0] ROUND_ADD = 41'd8355840;  // 255 * 32768
   localparam logic [24:0] RECIP_255 = 25'd16843010; // ceil(2^32 / 255)
   localparam logic [32:0] WT_ONE    = 33'h1_0000_0000;

   // Grid offsets of the eight bump taps and their gradient weights.
   function automatic bump_pt_type bump_pt(input logic [2:0] p);
      bump_pt_type r;
      unique case (p)
         3'd0: r = '{du: -2'sd1, dv: -2'sd1, wx:  4'sd1, wy:  4'sd1};
         3'd1: r = '{du: -2'sd1, dv:  2'sd0, wx:  4'sd4, wy:  4'sd0};
         3'd2: r = '{du: -2'sd1, dv:  2'sd1, wx:  4'sd1, wy: -4'sd1};
         3'd3: r = '{du:  2'sd0, dv: -2'sd1, wx:  4'sd0, wy:  4'sd4};
         3'd4: r = '{du:  2'sd0, dv:  2'sd1, wx:  4'sd0, wy: -4'sd4};
         3'd5: r = '{du:  2'sd1, dv: -2'sd1, wx: -4'sd1, wy:  4'sd1};
         3'd6: r = '{du:  2'sd1, dv:  2'sd0, wx: -4'sd4, wy:  4'sd0};
         default: r = '{du: 2'sd1, dv: 2'sd1, wx: -4'sd1, wy: -4'sd1};
      endcase
      return r;
   endfunction

   // Repeat or clamp a Q16 coordinate into 0..1.
   function automatic logic [16:0] fold(input logic signed [33:0] c, input logic clamp);
      logic [16:0] r;
      if (clamp) begin
         if (c > 34'sd65536) r = ONE_Q16;
         else if (c < 34'sd0) r = '0;
         else r = c[16:0];
      end else begin
         if (c > 34'sd65536) r = {1'b0, c[15:0]};
         else if (c < 34'sd0) r = (c[15:0] == 16'd0) ? ONE_Q16 : {1'b0, c[15:0]};
         else r = c[16:0];
      end
      return r;
   endfunction

   // Scale a Q16 value by a small signed weight (0, +-1, +-4).
   function automatic logic signed [20:0] scale_w(input logic [16:0] r,
                                                  input logic signed [3:0] w);
      logic signed [20:0] v;
      logic signed [20:0] s;
      v = $signed({4'b0, r});
      unique case (w)
         4'sd1:   s = v;
         -4'sd1:  s = -v;
         4'sd4:   s = v <<< 2;
         -4'sd4:  s = -(v <<< 2);
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

### hw/rtl/tsam_if.sv
// Valid/ready channel interfaces for sample requests and results.
interface tsam_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic signed [31:0] coord_u;
   logic signed [31:0] coord_v;
   logic [8:0]  texel_col;
   logic [8:0]  texel_row;
   logic [7:0]  texel_red;
   logic [7:0]  texel_green;
   logic [7:0]  texel_blue;
   modport source (output valid, action, coord_u, coord_v, texel_col, texel_row,
                   texel_red, texel_green, texel_blue, input ready);
   modport sink (input valid, action, coord_u, coord_v, texel_col, texel_row,
                 texel_red, texel_green, texel_blue, output ready);
endinterface

interface tsam_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [19:0] out_x;
   logic signed [19:0] out_y;
   logic signed [19:0] out_z;
   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

### hw/rtl/tsam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsam_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [AW-1:0]            waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [AW-1:0]            raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### hw/rtl/texture_sampler.sv
// Texture sampler top level: texel store, APB registers and sampling sequencer.
// Load writes one texel and gives no result. Each sample point runs on the shared
// multiplier; colour and normal sample one point, bump samples eight points.
// Not ready meanwhile.
// Reset restores register defaults and clears control state; the texel store
// is not cleared and holds undefined data until written.
module texture_sampler
   import tsam_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic        clock,
   input  logic        reset,
   tsam_req_if.sink    req_bus,
   tsam_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FOLD, ST_MULU, ST_MULV, ST_WGT, ST_READ, ST_MAC, ST_DIV, ST_ACC, ST_OUT
   } state_type;

   state_type state_ff;
   logic [9:0]  tex_width_ff, tex_height_ff;
   logic        filter_mode_ff, wrap_mode_ff;
   logic [16:0] step_u_ff, step_v_ff;

   logic [1:0]  act_ff;
   logic signed [31:0] u_ff, v_ff;
   logic [2:0]  pt_ff;
   logic [1:0]  k_ff, ch_ff;
   logic [16:0] fu_ff, fv_ff;
   logic [26:0] pu_ff, pv_ff;
   logic [9:0]  cl_ff, cr_ff, rl_ff, rr_ff;
   logic [32:0] wt_ff [4];
   logic [40:0] sum_ff [3];
   logic [16:0] chv_ff [3];
   logic signed [20:0] acc_x_ff, acc_y_ff;
   logic        rsp_valid_ff;
   logic signed [19:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   // configuration port
   logic       cfg_we;
   logic [2:0] cfg_idx;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cfg_idx)
         REG_TEX_WIDTH:   csr_prdata = {22'b0, tex_width_ff};
         REG_TEX_HEIGHT:  csr_prdata = {22'b0, tex_height_ff};
         REG_FILTER_MODE: csr_prdata = {31'b0, filter_mode_ff};
         REG_WRAP_MODE:   csr_prdata = {31'b0, wrap_mode_ff};
         REG_STEP_U:      csr_prdata = {15'b0, step_u_ff};
         REG_STEP_V:      csr_prdata = {15'b0, step_v_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff   <= 10'd512;
         tex_height_ff  <= 10'd512;
         filter_mode_ff <= 1'b0;
         wrap_mode_ff   <= 1'b0;
         step_u_ff      <= 17'd128;
         step_v_ff      <= 17'd128;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            REG_TEX_WIDTH:   tex_width_ff   <= csr_pwdata[9:0];
            REG_TEX_HEIGHT:  tex_height_ff  <= csr_pwdata[9:0];
            REG_FILTER_MODE: filter_mode_ff <= csr_pwdata[0];
            REG_WRAP_MODE:   wrap_mode_ff   <= csr_pwdata[0];
            REG_STEP_U:      step_u_ff      <= csr_pwdata[16:0];
            REG_STEP_V:      step_v_ff      <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   // effective dimensions
   logic [9:0] w_eff, h_eff;
   always_comb begin
      if (tex_width_ff == 10'd0) w_eff = 10'd1;
      else if (32'(tex_width_ff) > 32'(MAX_WIDTH)) w_eff = 10'(MAX_WIDTH);
      else w_eff = tex_width_ff;
      if (tex_height_ff == 10'd0) h_eff = 10'd1;
      else if (32'(tex_height_ff) > 32'(MAX_HEIGHT)) h_eff = 10'(MAX_HEIGHT);
      else h_eff = tex_height_ff;
   end

   // texel store
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [23:0]   ram_wdata, ram_rdata;
   logic [31:0]   waddr_full, raddr_full;
   logic [9:0]    rd_col, rd_row;

   assign req_bus.ready = (state_ff == ST_IDLE);

   assign ram_we = (state_ff == ST_IDLE) && req_bus.valid && (req_bus.action == ACT_LOAD)
                   && (32'(req_bus.texel_col) < 32'(MAX_WIDTH))
                   && (32'(req_bus.texel_row) < 32'(MAX_HEIGHT));
   assign waddr_full = 32'(req_bus.texel_row) * 32'(MAX_WIDTH) + 32'(req_bus.texel_col);
   assign ram_waddr  = waddr_full[AW-1:0];
   assign ram_wdata  = {req_bus.texel_red, req_bus.texel_green, req_bus.texel_blue};

   assign rd_col     = k_ff[1] ? cr_ff : cl_ff;
   assign rd_row     = k_ff[0] ? rr_ff : rl_ff;
   assign raddr_full = 32'(rd_row) * 32'(MAX_WIDTH) + 32'(rd_col);
   assign ram_raddr  = raddr_full[AW-1:0];
   assign ram_re     = (state_ff == ST_READ);

   tsam_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // point coordinates with bump offset
   bump_pt_type        pi;
   logic signed [33:0] off_u, off_v, cu, cv;
   logic [16:0]        fold_u, fold_v;
   always_comb begin
      pi = bump_pt(pt_ff);
      off_u = '0;
      off_v = '0;
      if (act_ff == ACT_BUMP) begin
         if (pi.du == 2'sd1) off_u = $signed({17'b0, step_u_ff});
         else if (pi.du == -2'sd1) off_u = -$signed({17'b0, step_u_ff});
         if (pi.dv == 2'sd1) off_v = $signed({17'b0, step_v_ff});
         else if (pi.dv == -2'sd1) off_v = -$signed({17'b0, step_v_ff});
      end
      cu = 34'(u_ff) + off_u;
      cv = 34'(v_ff) + off_v;
      fold_u = fold(cu, wrap_mode_ff);
      fold_v = ONE_Q16 - fold(cv, wrap_mode_ff);
   end

   // index and fraction derivation
   logic [10:0]        ci11, ri11;
   logic [9:0]         ci, ri;
   logic signed [27:0] pos_u, pos_v;
   logic signed [11:0] lo_u, lo_v, lo1_u, lo1_v;
   logic [15:0]        du, dv;
   logic [9:0]         cl, cr, rl, rr;
   always_comb begin
      ci11 = pu_ff[26:16];
      ri11 = pv_ff[26:16];
      ci = (ci11 >= {1'b0, w_eff}) ? w_eff - 10'd1 : ci11[9:0];
      ri = (ri11 >= {1'b0, h_eff}) ? h_eff - 10'd1 : ri11[9:0];
      pos_u = $signed({1'b0, pu_ff}) - 28'sd32768;
      pos_v = $signed({1'b0, pv_ff}) - 28'sd32768;
      lo_u = pos_u[27:16];
      lo_v = pos_v[27:16];
      du = pos_u[15:0];
      dv = pos_v[15:0];
      lo1_u = lo_u + 12'sd1;
      lo1_v = lo_v + 12'sd1;
      cl = lo_u[11] ? w_eff - 10'd1 : lo_u[9:0];
      rl = lo_v[11] ? h_eff - 10'd1 : lo_v[9:0];
      cr = (lo1_u >= $signed({2'b0, w_eff})) ? 10'd0 : lo1_u[9:0];
      rr = (lo1_v >= $signed({2'b0, h_eff})) ? 10'd0 : lo1_v[9:0];
   end

   // shared multiplier
   logic [32:0] mul_a;
   logic [24:0] mul_b;
   logic [57:0] prod;
   logic [7:0]  chan;
   logic [40:0] rnd_sum;
   always_comb begin
      unique case (ch_ff)
         2'd0:    chan = ram_rdata[23:16];
         2'd1:    chan = ram_rdata[15:8];
         default: chan = ram_rdata[7:0];
      endcase
      rnd_sum = sum_ff[ch_ff] + ROUND_ADD;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MULU: begin
            mul_a = 33'(fu_ff);
            mul_b = 25'(w_eff);
         end
         ST_MULV: begin
            mul_a = 33'(fv_ff);
            mul_b = 25'(h_eff);
         end
         ST_WGT: begin
            mul_a = k_ff[1] ? 33'(du) : 33'(ONE_Q16 - {1'b0, du});
            mul_b = k_ff[0] ? 25'(dv) : 25'(ONE_Q16 - {1'b0, dv});
         end
         ST_MAC: begin
            mul_a = wt_ff[k_ff];
            mul_b = 25'(chan);
         end
         ST_DIV: begin
            mul_a = 33'(rnd_sum[40:16]);
            mul_b = RECIP_255;
         end
         default: ;
      endcase
      prod = 58'(mul_a) * 58'(mul_b);
   end

   logic [1:0] k_last;
   assign k_last = filter_mode_ff ? 2'd3 : 2'd0;

   logic signed [19:0] norm_x, norm_y, norm_z;
   assign norm_x = 20'({2'b0, chv_ff[0], 1'b0}) - 20'sd65536;
   assign norm_y = 20'({2'b0, chv_ff[1], 1'b0}) - 20'sd65536;
   assign norm_z = 20'({2'b0, chv_ff[2], 1'b0}) - 20'sd65536;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid && req_bus.action != ACT_LOAD) begin
                  act_ff   <= req_bus.action;
                  u_ff     <= req_bus.coord_u;
                  v_ff     <= req_bus.coord_v;
                  pt_ff    <= 3'd0;
                  acc_x_ff <= '0;
                  acc_y_ff <= '0;
                  state_ff <= ST_FOLD;
               end
            end
            ST_FOLD: begin
               fu_ff     <= fold_u;
               fv_ff     <= fold_v;
               sum_ff[0] <= '0;
               sum_ff[1] <= '0;
               sum_ff[2] <= '0;
               k_ff      <= 2'd0;
               state_ff  <= ST_MULU;
            end
            ST_MULU: begin
               pu_ff    <= prod[26:0];
               state_ff <= ST_MULV;
            end
            ST_MULV: begin
               pv_ff    <= prod[26:0];
               state_ff <= ST_WGT;
            end
            ST_WGT: begin
               if (filter_mode_ff) begin
                  cl_ff <= cl;
                  cr_ff <= cr;
                  rl_ff <= rl;
                  rr_ff <= rr;
                  wt_ff[k_ff] <= prod[32:0];
                  k_ff <= k_ff + 2'd1;
                  if (k_ff == 2'd3) state_ff <= ST_READ;
               end else begin
                  cl_ff    <= ci;
                  rl_ff    <= ri;
                  wt_ff[0] <= WT_ONE;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               ch_ff    <= 2'd0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               sum_ff[ch_ff] <= sum_ff[ch_ff] + prod[40:0];
               if (ch_ff == 2'd2) begin
                  ch_ff <= 2'd0;
                  if (k_ff == k_last) begin
                     state_ff <= ST_DIV;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= ST_READ;
                  end
               end else begin
                  ch_ff <= ch_ff + 2'd1;
               end
            end
            ST_DIV: begin
               chv_ff[ch_ff] <= prod[48:32];
               if (ch_ff == 2'd2) state_ff <= ST_ACC;
               else ch_ff <= ch_ff + 2'd1;
            end
            ST_ACC: begin
               if (act_ff == ACT_BUMP) begin
                  acc_x_ff <= acc_x_ff + scale_w(chv_ff[0], pi.wx);
                  acc_y_ff <= acc_y_ff + scale_w(chv_ff[0], pi.wy);
                  if (pt_ff == 3'd7) begin
                     state_ff <= ST_OUT;
                  end else begin
                     pt_ff    <= pt_ff + 3'd1;
                     state_ff <= ST_FOLD;
                  end
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  priority if (act_ff == ACT_BUMP) begin
                     rsp_x_ff <= acc_x_ff[19:0];
                     rsp_y_ff <= acc_y_ff[19:0];
                     rsp_z_ff <= 20'sd65536;
                  end else if (act_ff == ACT_NORMAL) begin
                     rsp_x_ff <= norm_x;
                     rsp_y_ff <= norm_y;
                     rsp_z_ff <= norm_z;
                  end else begin
                     rsp_x_ff <= 20'(chv_ff[0]);
                     rsp_y_ff <= 20'(chv_ff[1]);
                     rsp_z_ff <= 20'(chv_ff[2]);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_x = rsp_x_ff;
   assign rsp_bus.out_y = rsp_y_ff;
   assign rsp_bus.out_z = rsp_z_ff;
endmodule
